/* src/tpfl_pkg.sv */
`timescale 1ns / 1ps
package tpfl_pkg;

  localparam int FIELD_W = 12;
  localparam int VAL_W = 13;

  typedef enum logic [3:0] {
    S_IDLE,
    S_X_RD,
    S_X_CHK,
    S_X_DIV,
    S_W_INIT,
    S_W_RD,
    S_W_CHK,
    S_W_DIV,
    S_I_RD,
    S_I_CHK,
    S_I_DIV,
    S_FIN,
    S_ONE,
    S_LIST
  } state_t;

endpackage

/* src/tpfl_div.sv */
`timescale 1ns / 1ps
module tpfl_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [tpfl_pkg::VAL_W-1:0]      dividend,
  input  logic [tpfl_pkg::FIELD_W-1:0]    divisor,
  output logic                            done,
  output logic [tpfl_pkg::VAL_W-1:0]      quotient,
  output logic [tpfl_pkg::FIELD_W-1:0]    remainder
);

  localparam int SW = $clog2(tpfl_pkg::VAL_W + 1);

  logic [SW-1:0]                   steps;
  logic                            running;
  logic [tpfl_pkg::VAL_W-1:0]      shreg;
  logic [tpfl_pkg::FIELD_W-1:0]    dsor;
  logic [tpfl_pkg::VAL_W-1:0]      trial;
  logic                            fits;

  assign trial = {remainder, shreg[tpfl_pkg::VAL_W-1]};
  assign fits = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps <= SW'(tpfl_pkg::VAL_W);
        shreg <= dividend;
        dsor <= divisor;
        remainder <= '0;
      end else if (running) begin
        remainder <= fits ? tpfl_pkg::FIELD_W'(trial - {1'b0, dsor})
                          : tpfl_pkg::FIELD_W'(trial);
        shreg <= {shreg[tpfl_pkg::VAL_W-2:0], 1'b0};
        quotient <= {quotient[tpfl_pkg::VAL_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/totient_prime_factor_lister.sv */
`timescale 1ns / 1ps
// table extension: each trial prime for each new number takes a read, a square check
// and a 13-step divide; the factor walk handles each prime factor of n and each factor of p-1,
// then passes through the S_FIN state before the first result word
// throughput: one query at a time, busy stays high until the last word is strobed
// reset: smallest factor table and prime list start with 2 and 3, no clearing pass
// results come out one word per cycle; the receiver cannot stall
module totient_prime_factor_lister #(
  parameter int TABLE_DEPTH = 4096,
  parameter int PRIME_SLOTS = 1024,
  parameter int MAX_FACTORS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] query_value,
  output logic        strobe,
  output logic [11:0] prime_factor,
  output logic        last_factor,
  output logic        totient_is_one,
  output logic        out_of_range
);

  localparam int FW = tpfl_pkg::FIELD_W;
  localparam int VW = tpfl_pkg::VAL_W;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(PRIME_SLOTS);
  localparam int CW = $clog2(PRIME_SLOTS + 1);
  localparam int FCW = $clog2(MAX_FACTORS + 1);
  localparam int IW = $clog2(MAX_FACTORS);

  tpfl_pkg::state_t state, state_next;

  logic [FW-1:0] smallest_factor_table [TABLE_DEPTH];
  logic [FW-1:0] prime_list [PRIME_SLOTS];
  logic [FW-1:0] sort_buffer [MAX_FACTORS];
  logic [FW-1:0] sort_next [MAX_FACTORS];

  logic [VW-1:0] n, n_next, m, m_next, m2, m2_next, cur, cur_next;
  logic [VW-1:0] watermark, watermark_next;
  logic [FW-1:0] prev, prev_next, preg, preg_next;
  logic [CW-1:0] pidx, pidx_next, prime_count, prime_count_next;
  logic [FCW-1:0] fill, fill_next;
  logic [IW-1:0] oidx, oidx_next;
  logic oor_flag, oor_flag_next;

  logic t_re, t_we, p_re, p_we;
  logic [AW-1:0] t_ra, t_wa;
  logic [FW-1:0] t_wd, t_rd, t_data;
  logic [PW-1:0] p_ra, p_wa;
  logic [FW-1:0] p_rd, p_data;
  logic [1:0] t_low_addr;
  logic t_low, p_low, p_low_addr;

  logic div_go, div_done;
  logic [VW-1:0] div_a, div_q;
  logic [FW-1:0] div_b, div_r;

  logic push;
  logic [FW-1:0] push_val;
  logic [MAX_FACTORS-1:0] gt;
  logic [2*FW-1:0] sq;

  tpfl_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (t_we) smallest_factor_table[t_wa] <= t_wd;
    if (t_re) begin
      t_rd <= smallest_factor_table[t_ra];
      t_low <= (t_ra < AW'(4));
      t_low_addr <= t_ra[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) prime_list[p_wa] <= cur[FW-1:0];
    if (p_re) begin
      p_rd <= prime_list[p_ra];
      p_low <= (p_ra < PW'(2));
      p_low_addr <= p_ra[0];
    end
  end

  assign t_data = t_low ? FW'(t_low_addr) : t_rd;
  assign p_data = p_low ? (p_low_addr ? FW'(3) : FW'(2)) : p_rd;
  assign sq = p_data * p_data;

  always_comb begin
    for (int k = 0; k < MAX_FACTORS; k++) begin
      gt[k] = (FCW'(k) < fill) && (sort_buffer[k] > push_val);
    end
    for (int k = 0; k < MAX_FACTORS; k++) begin
      if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
        sort_next[k] = sort_buffer[(k > 0) ? k - 1 : 0];
      end else if (gt[k] || FCW'(k) == fill) begin
        sort_next[k] = push_val;
      end else begin
        sort_next[k] = sort_buffer[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && fill < FCW'(MAX_FACTORS)) sort_buffer <= sort_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpfl_pkg::S_IDLE;
      prime_count <= CW'(2);
      watermark <= VW'(3);
      fill <= '0;
      oidx <= '0;
      pidx <= '0;
      oor_flag <= 1'b0;
    end else begin
      state <= state_next;
      prime_count <= prime_count_next;
      watermark <= watermark_next;
      fill <= fill_next;
      oidx <= oidx_next;
      pidx <= pidx_next;
      oor_flag <= oor_flag_next;
    end
    n <= n_next;
    m <= m_next;
    m2 <= m2_next;
    cur <= cur_next;
    prev <= prev_next;
    preg <= preg_next;
  end

  always_comb begin
    state_next = state;
    n_next = n;
    m_next = m;
    m2_next = m2;
    cur_next = cur;
    prev_next = prev;
    preg_next = preg;
    pidx_next = pidx;
    prime_count_next = prime_count;
    watermark_next = watermark;
    fill_next = fill;
    oidx_next = oidx;
    oor_flag_next = oor_flag;
    t_re = 1'b0;
    t_ra = AW'(m);
    t_we = 1'b0;
    t_wa = AW'(cur);
    t_wd = cur[FW-1:0];
    p_re = 1'b0;
    p_ra = pidx[PW-1:0];
    p_we = 1'b0;
    p_wa = prime_count[PW-1:0];
    div_go = 1'b0;
    div_a = m;
    div_b = preg;
    push = 1'b0;
    push_val = t_data;

    unique case (state)
      tpfl_pkg::S_IDLE: begin
        if (start) begin
          n_next = VW'(query_value);
          if (32'(query_value) > TABLE_DEPTH - 2) begin
            oor_flag_next = 1'b1;
            state_next = tpfl_pkg::S_ONE;
          end else if (VW'(query_value) >= watermark) begin
            cur_next = watermark + 1'b1;
            pidx_next = '0;
            state_next = tpfl_pkg::S_X_RD;
          end else begin
            state_next = tpfl_pkg::S_W_INIT;
          end
        end
      end
      tpfl_pkg::S_X_RD: begin
        if (pidx >= prime_count) begin
          t_we = 1'b1;
          if (prime_count < CW'(PRIME_SLOTS)) begin
            p_we = 1'b1;
            prime_count_next = prime_count + 1'b1;
          end
          if (cur == n + 1'b1) begin
            watermark_next = cur;
            state_next = tpfl_pkg::S_W_INIT;
          end else begin
            cur_next = cur + 1'b1;
            pidx_next = '0;
          end
        end else begin
          p_re = 1'b1;
          state_next = tpfl_pkg::S_X_CHK;
        end
      end
      tpfl_pkg::S_X_CHK: begin
        if (p_data == '0 || (2*FW)'(cur) < sq) begin
          pidx_next = prime_count;
          state_next = tpfl_pkg::S_X_RD;
        end else begin
          div_go = 1'b1;
          div_a = cur;
          div_b = p_data;
          state_next = tpfl_pkg::S_X_DIV;
        end
      end
      tpfl_pkg::S_X_DIV: begin
        if (div_done) begin
          if (div_r == '0) begin
            t_we = 1'b1;
            t_wd = p_data;
            if (cur == n + 1'b1) begin
              watermark_next = cur;
              state_next = tpfl_pkg::S_W_INIT;
            end else begin
              cur_next = cur + 1'b1;
              pidx_next = '0;
              state_next = tpfl_pkg::S_X_RD;
            end
          end else begin
            pidx_next = pidx + 1'b1;
            state_next = tpfl_pkg::S_X_RD;
          end
        end
      end
      tpfl_pkg::S_W_INIT: begin
        m_next = n;
        prev_next = '0;
        fill_next = '0;
        state_next = tpfl_pkg::S_W_RD;
      end
      tpfl_pkg::S_W_RD: begin
        if (m <= VW'(1)) begin
          state_next = tpfl_pkg::S_FIN;
        end else begin
          t_re = 1'b1;
          state_next = tpfl_pkg::S_W_CHK;
        end
      end
      tpfl_pkg::S_W_CHK: begin
        if (t_data < FW'(2) || VW'(t_data) > m) begin
          state_next = tpfl_pkg::S_FIN;
        end else begin
          preg_next = t_data;
          prev_next = t_data;
          if (t_data != prev) begin
            if (t_data != FW'(2)) begin
              m2_next = VW'(t_data) - 1'b1;
              state_next = tpfl_pkg::S_I_RD;
            end else begin
              div_go = 1'b1;
              div_b = t_data;
              state_next = tpfl_pkg::S_W_DIV;
            end
          end else begin
            push = 1'b1;
            if (fill < FCW'(MAX_FACTORS)) fill_next = fill + 1'b1;
            div_go = 1'b1;
            div_b = t_data;
            state_next = tpfl_pkg::S_W_DIV;
          end
        end
      end
      tpfl_pkg::S_W_DIV: begin
        if (div_done) begin
          m_next = div_q;
          state_next = tpfl_pkg::S_W_RD;
        end
      end
      tpfl_pkg::S_I_RD: begin
        if (m2 <= VW'(1)) begin
          div_go = 1'b1;
          state_next = tpfl_pkg::S_W_DIV;
        end else begin
          t_re = 1'b1;
          t_ra = AW'(m2);
          state_next = tpfl_pkg::S_I_CHK;
        end
      end
      tpfl_pkg::S_I_CHK: begin
        if (t_data < FW'(2) || VW'(t_data) > m2) begin
          div_go = 1'b1;
          state_next = tpfl_pkg::S_W_DIV;
        end else begin
          push = 1'b1;
          if (fill < FCW'(MAX_FACTORS)) fill_next = fill + 1'b1;
          div_go = 1'b1;
          div_a = m2;
          div_b = t_data;
          state_next = tpfl_pkg::S_I_DIV;
        end
      end
      tpfl_pkg::S_I_DIV: begin
        if (div_done) begin
          m2_next = div_q;
          state_next = tpfl_pkg::S_I_RD;
        end
      end
      tpfl_pkg::S_FIN: begin
        oidx_next = '0;
        oor_flag_next = 1'b0;
        state_next = (fill == '0) ? tpfl_pkg::S_ONE : tpfl_pkg::S_LIST;
      end
      tpfl_pkg::S_ONE: begin
        oor_flag_next = 1'b0;
        state_next = tpfl_pkg::S_IDLE;
      end
      tpfl_pkg::S_LIST: begin
        if (FCW'(oidx) + 1'b1 == fill) begin
          state_next = tpfl_pkg::S_IDLE;
        end else begin
          oidx_next = oidx + 1'b1;
        end
      end
      default: state_next = tpfl_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != tpfl_pkg::S_IDLE);
  assign strobe = (state == tpfl_pkg::S_ONE) || (state == tpfl_pkg::S_LIST);
  assign prime_factor = (state == tpfl_pkg::S_LIST) ? sort_buffer[oidx] : '0;
  assign last_factor = (state == tpfl_pkg::S_ONE) ||
                       ((state == tpfl_pkg::S_LIST) && (FCW'(oidx) + 1'b1 == fill));
  assign totient_is_one = (state == tpfl_pkg::S_ONE) && !oor_flag;
  assign out_of_range = (state == tpfl_pkg::S_ONE) && oor_flag;

endmodule
